@@ design/assert_macros.svh @@
// Assertion helpers for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/mlvv_pkg.sv @@
`timescale 1ns / 1ps
package mlvv_pkg;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS = 24;
  localparam logic signed [15:0] ANG_PI = 16'sd12868;
  localparam logic signed [16:0] ANG_TWO_PI = 17'sd25736;
  localparam logic signed [15:0] ANG_HALF_PI = 16'sd6434;
  localparam logic signed [15:0] ANG_PITCH_LIM = 16'sd12861;
  localparam logic signed [15:0] ANG_RESET_YAW = 16'sd13517;
  localparam logic signed [15:0] ANG_RIGHT_OFS = 16'sd6431;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032875;
  localparam logic signed [15:0] VEC_ONE = 16'sd16384;
  // floor(2^40 / two pi in Q3.12), for the yaw wrap quotient
  localparam logic signed [26:0] ANG_WRAP_RECIP = 27'sd42722708;
  localparam int ANG_WRAP_SHIFT = 40;

  localparam logic [1:0] CFG_WIDTH = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SPEED = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_ANG, ST_WRAP, ST_LOAD, ST_CORDIC,
    ST_PROD1, ST_PROD2, ST_PROD3, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic signed [15:0] a0;
    logic signed [15:0] a1;
    logic signed [15:0] a2;
  } cell_cmd_t;

  function automatic logic signed [31:0] atan_entry(input int i);
    case (i)
      0: atan_entry = 32'sd210828714;
      1: atan_entry = 32'sd124459457;
      2: atan_entry = 32'sd65760959;
      3: atan_entry = 32'sd33381290;
      4: atan_entry = 32'sd16755422;
      5: atan_entry = 32'sd8385879;
      6: atan_entry = 32'sd4193963;
      7: atan_entry = 32'sd2097109;
      8: atan_entry = 32'sd1048571;
      9: atan_entry = 32'sd524287;
      default: atan_entry = 32'sd1 <<< (28 - i);
    endcase
  endfunction

  function automatic logic signed [15:0] sat_vec(input logic signed [35:0] v);
    if (v > 36'sd16384) sat_vec = VEC_ONE;
    else if (v < -36'sd16384) sat_vec = -VEC_ONE;
    else sat_vec = v[15:0];
  endfunction

  function automatic logic signed [16:0] wrap_ang(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (r >= 18'sd12868) r = r - 18'sd25736;
    else if (r < -18'sd12868) r = r + 18'sd25736;
    wrap_ang = r[16:0];
  endfunction
endpackage

@@ design/mlvv_cell.sv @@
`timescale 1ns / 1ps
// One sine/cosine lane: fold the angle, then one CORDIC rotation per cycle.
module mlvv_cell import mlvv_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic start,
  input  logic [4:0] step,
  input  logic signed [15:0] ang,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);
  logic signed [33:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic neg_r;
  logic signed [16:0] r;
  logic signed [16:0] rf;
  logic signed [15:0] c, s;

  always_comb begin
    r = wrap_ang({{2{ang[15]}}, ang});
    rf = r;
    if (r > 17'(ANG_HALF_PI)) rf = r - 17'(ANG_PI);
    else if (r < -17'(ANG_HALF_PI)) rf = r + 17'(ANG_PI);
    c = sat_vec(36'((x_r + 34'sd32768) >>> 16));
    s = sat_vec(36'((y_r + 34'sd32768) >>> 16));
    cos_o = neg_r ? -c : c;
    sin_o = neg_r ? -s : s;
  end

  // load on start, rotate while the step count is in range
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CORDIC_GAIN_Q30;
      y_r <= '0;
      z_r <= 32'(rf) <<< 16;
      neg_r <= (r > 17'(ANG_HALF_PI)) || (r < -17'(ANG_HALF_PI));
    end else if (int'(step) < CORDIC_STEPS) begin
      if (!z_r[31]) begin
        x_r <= x_r - (y_r >>> step);
        y_r <= y_r + (x_r >>> step);
        z_r <= z_r - atan_entry(int'(step));
      end else begin
        x_r <= x_r + (y_r >>> step);
        y_r <= y_r - (x_r >>> step);
        z_r <= z_r + atan_entry(int'(step));
      end
    end
  end
endmodule

@@ design/mlvv_chain.sv @@
`timescale 1ns / 1ps
// Row of three CORDIC lanes sharing one step counter.
module mlvv_chain import mlvv_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  cell_cmd_t cmd,
  input  logic [4:0] step,
  output logic signed [15:0] sin_o [3],
  output logic signed [15:0] cos_o [3]
);
  logic signed [15:0] ang [3];
  assign ang[0] = cmd.a0;
  assign ang[1] = cmd.a1;
  assign ang[2] = cmd.a2;
  for (genvar g = 0; g < 3; g++) begin : g_cell
    mlvv_cell #(.CORDIC_STEPS(CORDIC_STEPS)) u_cell (
      .clk(clk), .start(cmd.start), .step(step), .ang(ang[g]),
      .sin_o(sin_o[g]), .cos_o(cos_o[g]));
  end
endmodule

@@ design/mouse_look_view_vectors_core.sv @@
`timescale 1ns / 1ps
// Mouse-look orientation core.
// Input channel in_*: one beat per camera update (operation, capture,
// cursor position, frame time). Output channel out_*: one beat per input
// beat carrying the stored forward, right and up vectors in Q1.14.
// An update with capture on runs the increment multiplies, pitch update and
// yaw wrap quotient, yaw remainder, lane load, the CORDIC rotations in three
// parallel lanes and the products (ST_PROD1 to ST_PROD3), then raises
// out_valid. Reset operations and capture-off updates raise out_valid the
// cycle after the accepting edge. One item is in flight at a time: the next
// beat is taken only once the result beat is accepted.
// Reset (rst_n low, synchronous) restores default registers, zero angles
// and vectors. When the receiver stalls, the result beat holds in out_*
// and no new input beat is taken until it is accepted.
// Configuration writes via cfg_we/cfg_index/cfg_data only while idle.
`include "assert_macros.svh"
module mouse_look_view_vectors_core import mlvv_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_operation,
  input  logic in_capture_on,
  input  logic [11:0] in_cursor_x,
  input  logic [11:0] in_cursor_y,
  input  logic [15:0] in_delta_time,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] out_forward_x,
  output logic signed [15:0] out_forward_y,
  output logic signed [15:0] out_forward_z,
  output logic signed [15:0] out_right_x,
  output logic signed [15:0] out_right_z,
  output logic signed [15:0] out_up_x,
  output logic signed [15:0] out_up_y,
  output logic signed [15:0] out_up_z
);
  logic [12:0] width_r, height_r;
  logic [15:0] speed_r;
  state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic [11:0] cx_r, cy_r;
  logic [15:0] dt_r;
  logic [31:0] mag_r;
  logic signed [14:0] offx_r, offy_r;
  logic signed [25:0] incx_r, incy_r;
  logic signed [26:0] yt_r;
  logic signed [13:0] yq_r;
  logic signed [53:0] yprod;
  logic signed [26:0] yrem;
  logic signed [26:0] psum;
  logic signed [15:0] yaw_r, pitch_r;
  logic signed [15:0] fx_r, fy_r, fz_r, rx_r, rz_r, ux_r, uy_r, uz_r;
  logic signed [15:0] sn [3];
  logic signed [15:0] cs [3];
  cell_cmd_t cmd;
  logic signed [31:0] pa, pb;
  logic signed [15:0] fxn, fzn;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 13'd1280;
      height_r <= 13'd720;
      speed_r <= 16'd328;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH: width_r <= cfg_data[12:0];
        CFG_HEIGHT: height_r <= cfg_data[12:0];
        CFG_SPEED: speed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign cmd.start = (state_r == ST_LOAD);
  assign cmd.a0 = yaw_r;
  assign cmd.a1 = pitch_r;
  assign cmd.a2 = 16'(yaw_r - ANG_RIGHT_OFS);

  mlvv_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_chain (
    .clk(clk), .cmd(cmd), .step(step_r), .sin_o(sn), .cos_o(cs));

  function automatic logic signed [25:0] round_inc(
    input logic [31:0] m, input logic signed [14:0] o);
    logic [45:0] p;
    logic [24:0] q;
    logic [13:0] ao;
    ao = o[14] ? 14'(-o) : o[13:0];
    p = m * ao;
    q = 25'((p + 46'd1048576) >> 21);
    round_inc = o[14] ? -26'(q) : 26'(q);
  endfunction

  function automatic logic signed [15:0] mq(input logic signed [32:0] p);
    mq = sat_vec(36'((p + 33'sd8192) >>> 14));
  endfunction

  // yaw wrap: quotient by reciprocal, remainder, pitch sum
  assign yprod = yt_r * ANG_WRAP_RECIP;
  assign yrem = yt_r - 27'(yq_r) * 27'(ANG_TWO_PI);
  assign psum = 27'(pitch_r) + 27'(incy_r);

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        if (in_operation || !in_capture_on) state_nxt = ST_OUT;
        else state_nxt = ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_ANG;
      ST_ANG: state_nxt = ST_WRAP;
      ST_WRAP: state_nxt = ST_LOAD;
      ST_LOAD: begin
        state_nxt = ST_CORDIC;
        step_nxt = '0;
      end
      ST_CORDIC: begin
        step_nxt = step_r + 5'd1;
        if (int'(step_r) == CORDIC_STEPS - 1) state_nxt = ST_PROD1;
      end
      ST_PROD1: state_nxt = ST_PROD2;
      ST_PROD2: state_nxt = ST_PROD3;
      ST_PROD3: state_nxt = ST_OUT;
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= 5'(MAX_STEPS);
    end else begin
      state_r <= state_nxt;
      step_r <= (state_r == ST_CORDIC && state_nxt != ST_CORDIC) ? 5'(MAX_STEPS) : step_nxt;
    end
  end

  assign pa = cs[1] * sn[0];
  assign pb = cs[1] * cs[0];
  assign fxn = mq(33'(pa));
  assign fzn = mq(33'(pb));

  // datapath: angles and vectors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r <= '0; pitch_r <= '0;
      fx_r <= '0; fy_r <= '0; fz_r <= '0; rx_r <= '0; rz_r <= '0;
      ux_r <= '0; uy_r <= '0; uz_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          cx_r <= in_cursor_x; cy_r <= in_cursor_y; dt_r <= in_delta_time;
          if (in_operation) begin
            yaw_r <= ANG_RESET_YAW;
            pitch_r <= '0;
          end
        end
        ST_MUL1: begin
          mag_r <= speed_r * dt_r;
          offx_r <= 15'($signed({2'b0, width_r}) - $signed({2'b0, cx_r, 1'b0}));
          offy_r <= 15'($signed({2'b0, height_r}) - $signed({2'b0, cy_r, 1'b0}));
        end
        ST_MUL2: incx_r <= round_inc(mag_r, offx_r);
        ST_MUL3: begin
          incy_r <= round_inc(mag_r, offy_r);
          yt_r <= 27'(yaw_r) + 27'(incx_r) + 27'(ANG_PI);
        end
        ST_ANG: begin
          yq_r <= 14'(yprod >>> ANG_WRAP_SHIFT);
          if (psum > 27'(ANG_PITCH_LIM)) pitch_r <= ANG_PITCH_LIM;
          else if (psum < -27'(ANG_PITCH_LIM)) pitch_r <= -ANG_PITCH_LIM;
          else pitch_r <= 16'(psum);
        end
        // fix the quotient estimate by one either way and recenter
        ST_WRAP: begin
          if (yrem < 27'sd0) yaw_r <= 16'(yrem + 27'(ANG_TWO_PI) - 27'(ANG_PI));
          else if (yrem >= 27'(ANG_TWO_PI))
            yaw_r <= 16'(yrem - 27'(ANG_TWO_PI) - 27'(ANG_PI));
          else yaw_r <= 16'(yrem - 27'(ANG_PI));
        end
        ST_PROD1: begin
          fx_r <= fxn; fz_r <= fzn; fy_r <= sn[1];
          rx_r <= sn[2]; rz_r <= cs[2];
        end
        ST_PROD2: begin
          ux_r <= mq(-33'(rz_r * fy_r));
          uz_r <= mq(33'(rx_r * fy_r));
        end
        ST_PROD3: uy_r <= mq(33'(rz_r * fx_r) - 33'(rx_r * fz_r));
        default: ;
      endcase
    end
  end

  assign out_forward_x = fx_r;
  assign out_forward_y = fy_r;
  assign out_forward_z = fz_r;
  assign out_right_x = rx_r;
  assign out_right_z = rz_r;
  assign out_up_x = ux_r;
  assign out_up_y = uy_r;
  assign out_up_z = uz_r;

  `ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
  `ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_up_y))
  `ASSERT_IMP(a_pitch, clk, rst_n, 1'b1, pitch_r <= ANG_PITCH_LIM && pitch_r >= -ANG_PITCH_LIM)
endmodule

@@ verif/mouse_look_view_vectors_core_tb.sv @@
`timescale 1ns / 1ps
module mouse_look_view_vectors_core_tb;
  import mlvv_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam bit OP_UPDATE = 1'b0;
  localparam bit OP_RESET_ANGLES = 1'b1;

  typedef struct {
    logic signed [15:0] fx, fy, fz, rx, rz, ux, uy, uz;
  } view_vectors_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_WIDTH;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = 1'b0;
  logic in_capture_on = 1'b0;
  logic [11:0] in_cursor_x = '0;
  logic [11:0] in_cursor_y = '0;
  logic [15:0] in_delta_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_forward_x, out_forward_y, out_forward_z;
  logic signed [15:0] out_right_x, out_right_z, out_up_x, out_up_y, out_up_z;

  // Model state
  longint scr_w, scr_h, look_gain;
  longint yaw, pitch;
  view_vectors_t cur_vec;
  view_vectors_t expected_views[$];

  int send_idle_pct, recv_idle_pct;
  int error_count = 0;

  always #2 clk = ~clk;

  mouse_look_view_vectors_core dut (.*);

  function automatic longint fl_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v - 1) >>> s) - 1;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint wrap_to_pi(longint a);
    longint r;
    r = (a + 12868) % 25736;
    if (r < 0) r += 25736;
    return r - 12868;
  endfunction

  function automatic longint arctan_q28(int i);
    longint tbl[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                        8385879, 4193963, 2097109, 1048571, 524287};
    if (i < 10) return tbl[i];
    return longint'(1) << (28 - i);
  endfunction

  // Rotate a gain-scaled unit vector to the angle; returns {sin, cos}
  task automatic rotate_unit(input longint a, output longint s, output longint c);
    longint r, x, y, z, nx;
    bit flip;
    r = wrap_to_pi(a);
    flip = 1'b0;
    if (r > 6434) begin
      r -= 12868;
      flip = 1'b1;
    end else if (r < -6434) begin
      r += 12868;
      flip = 1'b1;
    end
    x = 652032875;
    y = 0;
    z = r * 65536;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - fl_shift(y, i);
        y = y + fl_shift(x, i);
        z -= arctan_q28(i);
      end else begin
        nx = x + fl_shift(y, i);
        y = y - fl_shift(x, i);
        z += arctan_q28(i);
      end
      x = nx;
    end
    c = clamp_unit(fl_shift(x + 32768, 16));
    s = clamp_unit(fl_shift(y + 32768, 16));
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  function automatic longint q14_mul(longint p);
    return clamp_unit(fl_shift(p + 8192, 14));
  endfunction

  function automatic longint look_increment(longint dim, longint pos, longint dt);
    longint ofs, mag, q;
    ofs = dim - 2 * pos;
    mag = look_gain * dt * (ofs < 0 ? -ofs : ofs);
    q = (mag + (longint'(1) << 20)) >>> 21;
    return ofs < 0 ? -q : q;
  endfunction

  // Advance camera angles and derive the vectors for one beat
  task automatic predict_view(input bit op, input bit cap, input longint cx,
                              input longint cy, input longint dt);
    longint p, sy, cyw, sp, cp, sr, cr, fx, fz;
    if (op == OP_RESET_ANGLES) begin
      yaw = 13517;
      pitch = 0;
    end else if (cap) begin
      yaw = wrap_to_pi(yaw + look_increment(scr_w, cx, dt));
      p = pitch + look_increment(scr_h, cy, dt);
      if (p > 12861) p = 12861;
      else if (p < -12861) p = -12861;
      pitch = p;
      rotate_unit(yaw, sy, cyw);
      rotate_unit(pitch, sp, cp);
      rotate_unit(yaw - 6431, sr, cr);
      fx = q14_mul(cp * sy);
      fz = q14_mul(cp * cyw);
      cur_vec.fx = 16'(fx);
      cur_vec.fy = 16'(sp);
      cur_vec.fz = 16'(fz);
      cur_vec.rx = 16'(sr);
      cur_vec.rz = 16'(cr);
      cur_vec.ux = 16'(q14_mul(-(cr * sp)));
      cur_vec.uy = 16'(q14_mul(cr * fx - sr * fz));
      cur_vec.uz = 16'(q14_mul(sr * sp));
    end
    expected_views.push_back(cur_vec);
  endtask

  task automatic send_beat(input bit op, input bit cap, input int cx, input int cy,
                           input int dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_capture_on <= cap;
    in_cursor_x <= cx[11:0];
    in_cursor_y <= cy[11:0];
    in_delta_time <= dt[15:0];
    predict_view(op, cap, longint'(cx), longint'(cy), longint'(dt));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) scr_w = longint'(val & 'h1fff);
    else if (idx == CFG_HEIGHT) scr_h = longint'(val & 'h1fff);
    else if (idx == CFG_SPEED) look_gain = longint'(val & 'hffff);
  endtask

  // Receiver: random stall, compare each beat with the oldest prediction
  always @(posedge clk) begin
    view_vectors_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          $display("%0t: unexpected result beat fx=%0d", $time, out_forward_x);
          error_count++;
        end else begin
          e = expected_views.pop_front();
          if (e.fx !== out_forward_x || e.fy !== out_forward_y ||
              e.fz !== out_forward_z || e.rx !== out_right_x ||
              e.rz !== out_right_z || e.ux !== out_up_x ||
              e.uy !== out_up_y || e.uz !== out_up_z) begin
            $display("%0t: mismatch expected f=(%0d %0d %0d) r=(%0d %0d) u=(%0d %0d %0d)",
                     $time, e.fx, e.fy, e.fz, e.rx, e.rz, e.ux, e.uy, e.uz);
            $display("%0t:          actual f=(%0d %0d %0d) r=(%0d %0d) u=(%0d %0d %0d)",
                     $time, out_forward_x, out_forward_y, out_forward_z, out_right_x,
                     out_right_z, out_up_x, out_up_y, out_up_z);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed();
    send_beat(OP_UPDATE, 1'b1, 640, 360, 1000);
    send_beat(OP_UPDATE, 1'b1, 0, 0, 65535);
    send_beat(OP_UPDATE, 1'b1, 4095, 4095, 65535);
    send_beat(OP_UPDATE, 1'b1, 4095, 0, 0);
    send_beat(OP_UPDATE, 1'b0, 100, 200, 5000);
    send_beat(OP_RESET_ANGLES, 1'b0, 4095, 4095, 65535);
    send_beat(OP_UPDATE, 1'b0, 10, 10, 10);
    send_beat(OP_UPDATE, 1'b1, 640, 360, 0);
    send_beat(OP_RESET_ANGLES, 1'b1, 0, 0, 0);
    send_beat(OP_UPDATE, 1'b1, 641, 359, 3000);
    for (int i = 0; i < 6; i++) send_beat(OP_UPDATE, 1'b1, 0, 4095, 65535);
    for (int i = 0; i < 6; i++) send_beat(OP_UPDATE, 1'b1, 4095, 0, 65535);
    wait_drained();
  endtask

  task automatic test_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 5) send_beat(OP_RESET_ANGLES, 1'($urandom_range(1)), $urandom_range(4095),
                           $urandom_range(4095), $urandom_range(65535));
      else if (r < 12) send_beat(OP_UPDATE, 1'b0, $urandom_range(4095),
                                 $urandom_range(4095), $urandom_range(65535));
      else if (r < 70) send_beat(OP_UPDATE, 1'b1, $urandom_range(4095),
                                 $urandom_range(4095), $urandom_range(4000));
      else send_beat(OP_UPDATE, 1'b1, $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(65535));
      // hold off until the pipe is empty now and then
      if ($urandom_range(99) == 0) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_WIDTH, 1);
    write_reg(CFG_HEIGHT, 4096);
    write_reg(CFG_SPEED, 65535);
    test_random(60);
    write_reg(CFG_WIDTH, 4096);
    write_reg(CFG_HEIGHT, 1);
    write_reg(CFG_SPEED, 0);
    test_random(40);
    write_reg(CFG_WIDTH, 8191);
    write_reg(CFG_HEIGHT, 0);
    write_reg(CFG_SPEED, 4000);
    test_random(60);
    write_reg(CFG_WIDTH, 1921);
    write_reg(CFG_HEIGHT, 1080);
    write_reg(CFG_SPEED, 328);
  endtask

  initial begin
    scr_w = 1280;
    scr_h = 720;
    look_gain = 328;
    yaw = 0;
    pitch = 0;
    cur_vec = '{default: 0};
    send_idle_pct = 23;
    recv_idle_pct = 50;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(340);
    send_idle_pct = 50;
    recv_idle_pct = 23;
    test_config_sweep();
    test_random(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(400);
    if (error_count == 0) $display("mouse_look_view_vectors_core regression: pass");
    else $display("mouse_look_view_vectors_core regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("mouse_look_view_vectors_core regression: fail");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+design
design/mlvv_pkg.sv
design/mlvv_cell.sv
design/mlvv_chain.sv
design/mouse_look_view_vectors_core.sv
verif/mouse_look_view_vectors_core_tb.sv
